// ===== hdl/bsa_pkg.sv =====
// Package: widths, sequencer states and helpers for the bounding sphere accumulator.
package bsa_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 8;
	localparam int DW  = COORD_BITS + 1;
	localparam int LW  = COORD_BITS + 2;
	localparam int FW  = COORD_BITS + 3;
	localparam int SQW = 2 * DW;
	localparam int PW  = 2 * LW;
	localparam int RW  = COORD_BITS + 4;
	localparam int SW  = COORD_BITS + 3;
	localparam int CW  = $clog2(LW + 1);
	localparam int QB  = LW;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-1:0] rad_t;
	typedef logic signed [DW-1:0] diff_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_LEN,
		ST_MUL,
		ST_NUM,
		ST_DIV,
		ST_AXIS
	} state_t;

	function automatic logic [DW-1:0] mag(input diff_t v);
		logic [DW-1:0] u;
		u = v;
		mag = v[DW-1] ? (~u + 1'b1) : u;
	endfunction

	function automatic coord_t sat_coord(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = SW'((1 << (COORD_BITS - 1)) - 1);
		lo = -hi - SW'(1);
		if (v > hi) begin
			sat_coord = coord_t'(hi);
		end else if (v < lo) begin
			sat_coord = coord_t'(lo);
		end else begin
			sat_coord = v[COORD_BITS-1:0];
		end
	endfunction

endpackage

// ===== hdl/bounding_sphere_accumulator.sv =====
// Top level: running bounding sphere with one shared multiplier and subtractor.
//
//  channel | direction | handshake         | payload
//  input   | in        | in_valid/in_stall  | req_type, in_x, in_y, in_z, in_radius
//  output  | out       | out_valid/out_stall| out_x, out_y, out_z, out_radius, is_empty
//
// Clear and add-to-empty go from acceptance straight to commit. An add that grows the
// sphere runs: accept, the three squares, 25 square-root steps, length, per axis a multiply,
// a rounding add, 26 division steps on the shared subtractor and an update, then commit.
// An add that does not grow ends after the length step; one whose centers coincide updates only x.
// in_stall is high from acceptance until the result is committed to the output register.
// A stalled output holds the next result in the commit step. arst_n clears control and state.
module bounding_sphere_accumulator
	import bsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] in_x,
	input  logic [COORD_BITS-1:0] in_y,
	input  logic [COORD_BITS-1:0] in_z,
	input  logic [COORD_BITS-1:0] in_radius,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y,
	output logic [COORD_BITS-1:0] out_z,
	output logic [COORD_BITS-1:0] out_radius,
	output logic                  is_empty
);

	state_t state_q, state_d;
	logic fin_q;

	coord_t cx_q, cy_q, cz_q;
	rad_t   cr_q;
	logic   ce_q;

	coord_t nc_q [3];
	rad_t   nr_q;
	logic   ne_q;

	diff_t d_q [3];
	rad_t  rin_q;

	logic [SQW-1:0] acc_q;
	logic [PW-1:0]  prod_q;
	logic [RW-1:0]  rem_q;
	logic [DW-1:0]  root_q;
	logic [LW-1:0]  len_q;
	logic [LW-1:0]  s_q;
	logic [QB-1:0]  num_q;
	logic [LW-1:0]  quot_q;
	logic [CW-1:0]  cnt_q;
	logic [1:0]     ax_q;
	logic           zl_q;

	logic           out_valid_q;
	coord_t         ox_q, oy_q, oz_q;
	rad_t           or_q;
	logic           oe_q;

	logic           accept;
	logic           commit;
	logic [1:0]     ax_sel;
	diff_t          d_sel;
	logic [DW-1:0]  mul_a;
	logic [LW-1:0]  mul_b;
	logic [PW-1:0]  mul_p;
	logic [RW-1:0]  sub_a;
	logic [RW-1:0]  sub_b;
	logic [RW:0]    sub_r;
	logic           sub_ge;
	logic [LW-1:0]  len_c;
	logic [FW-1:0]  far_c;
	logic [FW:0]    nr_sum;
	logic [FW-1:0]  nr_c;
	logic [FW-1:0]  s_c;
	logic [PW:0]    num_c;
	logic signed [SW-1:0] ax_sum;
	diff_t          dx_c, dy_c, dz_c;

	assign accept = (state_q == ST_IDLE) && !fin_q && in_valid;
	assign commit = fin_q && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != ST_IDLE) || fin_q;

	assign dx_c = $signed({in_x[COORD_BITS-1], in_x}) - $signed({cx_q[COORD_BITS-1], cx_q});
	assign dy_c = $signed({in_y[COORD_BITS-1], in_y}) - $signed({cy_q[COORD_BITS-1], cy_q});
	assign dz_c = $signed({in_z[COORD_BITS-1], in_z}) - $signed({cz_q[COORD_BITS-1], cz_q});

	assign ax_sel = (state_q == ST_SQ) ? cnt_q[1:0] : ax_q;

	always_comb begin
		case (ax_sel)
			2'd0:    d_sel = d_q[0];
			2'd1:    d_sel = d_q[1];
			default: d_sel = d_q[2];
		endcase
	end

	assign mul_a = mag(d_sel);
	assign mul_b = (state_q == ST_SQ) ? LW'(mag(d_sel)) : s_q;
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	always_comb begin
		if (state_q == ST_ROOT) begin
			sub_a = {rem_q[RW-3:0], acc_q[SQW-1:SQW-2]};
			sub_b = RW'({root_q, 2'b01});
		end else begin
			sub_a = RW'({rem_q[LW-1:0], num_q[QB-1]});
			sub_b = RW'(len_q);
		end
	end

	assign sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge = !sub_r[RW];

	assign len_c  = LW'(root_q) + LW'(rem_q != '0);
	assign far_c  = FW'(len_c) + FW'(rin_q);
	assign nr_sum = (FW+1)'(cr_q) + (FW+1)'(far_c) + (FW+1)'(1);
	assign nr_c   = nr_sum[FW:1];
	assign s_c    = (far_c - FW'(cr_q)) >> 1;
	assign num_c  = (PW+1)'(prod_q) + (PW+1)'(len_q >> 1);

	always_comb begin
		logic neg;
		logic signed [SW-1:0] cext;
		logic signed [SW-1:0] qext;
		neg  = !zl_q && d_sel[DW-1];
		cext = SW'(nc_q[ax_q]);
		qext = $signed({1'b0, quot_q});
		ax_sum = neg ? (cext - qext) : (cext + qext);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !req_type && !ce_q) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (cnt_q == CW'(3)) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (cnt_q == CW'(DW - 1)) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (far_c > FW'(cr_q)) begin
					state_d = (len_c == '0) ? ST_AXIS : ST_MUL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL:  state_d = ST_NUM;
			ST_NUM:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CW'(QB - 1)) begin
					state_d = ST_AXIS;
				end
			end
			ST_AXIS: begin
				state_d = (zl_q || ax_q == 2'd2) ? ST_IDLE : ST_MUL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= 1'b0;
			cx_q        <= '0;
			cy_q        <= '0;
			cz_q        <= '0;
			cr_q        <= '0;
			ce_q        <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (req_type || ce_q)) begin
				fin_q <= 1'b1;
			end else if ((state_q == ST_LEN && state_d == ST_IDLE) ||
			             (state_q == ST_AXIS && state_d == ST_IDLE)) begin
				fin_q <= 1'b1;
			end else if (commit) begin
				fin_q <= 1'b0;
			end
			if (commit) begin
				cx_q        <= nc_q[0];
				cy_q        <= nc_q[1];
				cz_q        <= nc_q[2];
				cr_q        <= nr_q;
				ce_q        <= ne_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ox_q <= nc_q[0];
			oy_q <= nc_q[1];
			oz_q <= nc_q[2];
			or_q <= nr_q;
			oe_q <= ne_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type) begin
						nc_q[0] <= '0;
						nc_q[1] <= '0;
						nc_q[2] <= '0;
						nr_q    <= '0;
						ne_q    <= 1'b1;
					end else if (ce_q) begin
						nc_q[0] <= in_x;
						nc_q[1] <= in_y;
						nc_q[2] <= in_z;
						nr_q    <= in_radius;
						ne_q    <= 1'b0;
					end else begin
						nc_q[0] <= cx_q;
						nc_q[1] <= cy_q;
						nc_q[2] <= cz_q;
						nr_q    <= cr_q;
						ne_q    <= 1'b0;
					end
					d_q[0] <= dx_c;
					d_q[1] <= dy_c;
					d_q[2] <= dz_c;
					rin_q  <= in_radius;
					acc_q  <= '0;
					cnt_q  <= '0;
					zl_q   <= 1'b0;
				end
			end
			ST_SQ: begin
				if (cnt_q != '0) begin
					acc_q <= acc_q + prod_q[SQW-1:0];
				end
				prod_q <= mul_p;
				if (cnt_q == CW'(3)) begin
					cnt_q  <= '0;
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_ROOT: begin
				if (sub_ge) begin
					rem_q  <= sub_r[RW-1:0];
					root_q <= {root_q[DW-2:0], 1'b1};
				end else begin
					rem_q  <= sub_a;
					root_q <= {root_q[DW-2:0], 1'b0};
				end
				acc_q <= {acc_q[SQW-3:0], 2'b00};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_LEN: begin
				len_q <= len_c;
				ax_q  <= 2'd0;
				if (far_c > FW'(cr_q)) begin
					nr_q <= (nr_c > FW'({COORD_BITS{1'b1}})) ? '1 : nr_c[COORD_BITS-1:0];
					s_q  <= s_c[LW-1:0];
					if (len_c == '0) begin
						zl_q   <= 1'b1;
						quot_q <= s_c[LW-1:0];
					end
				end
			end
			ST_MUL: begin
				prod_q <= mul_p;
			end
			ST_NUM: begin
				rem_q <= RW'(num_c >> QB);
				num_q <= num_c[QB-1:0];
				cnt_q <= '0;
			end
			ST_DIV: begin
				quot_q <= {quot_q[LW-2:0], sub_ge};
				rem_q  <= sub_ge ? sub_r[RW-1:0] : sub_a;
				num_q  <= {num_q[QB-2:0], 1'b0};
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_AXIS: begin
				nc_q[ax_q] <= sat_coord(ax_sum);
				ax_q       <= ax_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_x      = ox_q;
	assign out_y      = oy_q;
	assign out_z      = oz_q;
	assign out_radius = or_q;
	assign is_empty   = oe_q;

endmodule

// ===== hdl/bsa_checker.sv =====
// Checker: port-level properties of the bounding sphere accumulator, bound to the top level.
module bsa_checker
	import bsa_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  req_type,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [COORD_BITS-1:0] out_x,
	input logic [COORD_BITS-1:0] out_y,
	input logic [COORD_BITS-1:0] out_z,
	input logic [COORD_BITS-1:0] out_radius,
	input logic                  is_empty
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_radius)
		&& $stable(is_empty))
		else $error("stalled output beat changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a beat is in work");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> out_x == '0 && out_y == '0 && out_z == '0
		&& out_radius == '0)
		else $error("empty sphere with nonzero fields");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type && !(out_valid && out_stall)
		|=> ##1 out_valid && is_empty)
		else $error("clear did not yield an empty beat");

endmodule

bind bounding_sphere_accumulator bsa_checker u_bsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.req_type   (req_type),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_x      (out_x),
	.out_y      (out_y),
	.out_z      (out_z),
	.out_radius (out_radius),
	.is_empty   (is_empty)
);

// ===== tb/sv/bsa_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard: watches both channels, predicts the running bounding sphere and compares results.
module bsa_scoreboard
	import bsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] in_x,
	input  logic [COORD_BITS-1:0] in_y,
	input  logic [COORD_BITS-1:0] in_z,
	input  logic [COORD_BITS-1:0] in_radius,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [COORD_BITS-1:0] out_x,
	input  logic [COORD_BITS-1:0] out_y,
	input  logic [COORD_BITS-1:0] out_z,
	input  logic [COORD_BITS-1:0] out_radius,
	input  logic                  is_empty,
	output int                    errors,
	output int                    pending
);

	localparam longint CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;
	localparam longint unsigned RMAX = (64'd1 << COORD_BITS) - 1;

	typedef struct packed {
		rad_t x;
		rad_t y;
		rad_t z;
		rad_t radius;
		logic empty;
	} sphere_t;

	sphere_t sphere_q[$];
	longint cx, cy, cz;
	longint unsigned crad;
	bit cempty;

	function automatic longint clamp_coord(input longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic longint unsigned root_up(input logic [127:0] s);
		longint unsigned r;
		logic [127:0] c;
		r = 0;
		for (int b = 40; b >= 0; b--) begin
			c = {64'd0, r | (64'd1 << b)};
			if (c * c <= s) r = c[63:0];
		end
		if ({64'd0, r} * {64'd0, r} < s) r++;
		return r;
	endfunction

	function automatic longint shift_axis(input longint c, input longint d,
			input longint unsigned s, input longint unsigned len);
		longint unsigned m, q;
		m = (d < 0) ? longint'(-d) : longint'(d);
		q = (m * s + (len >> 1)) / len;
		return clamp_coord(d < 0 ? c - longint'(q) : c + longint'(q));
	endfunction

	task automatic grow_sphere(input logic clr, input longint x, input longint y,
			input longint z, input longint unsigned r);
		longint dx, dy, dz;
		longint unsigned len, far, nr, s;
		logic [127:0] sq;
		if (clr) begin
			cx = 0; cy = 0; cz = 0; crad = 0; cempty = 1;
		end else if (cempty) begin
			cx = x; cy = y; cz = z; crad = r; cempty = 0;
		end else begin
			dx = x - cx; dy = y - cy; dz = z - cz;
			sq = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
			len = root_up(sq);
			far = len + r;
			if (far > crad) begin
				nr = (crad + far + 1) >> 1;
				s = (far - crad) >> 1;
				if (len == 0) begin
					cx = clamp_coord(cx + longint'(s));
				end else begin
					cx = shift_axis(cx, dx, s, len);
					cy = shift_axis(cy, dy, s, len);
					cz = shift_axis(cz, dz, s, len);
				end
				crad = (nr > RMAX) ? RMAX : nr;
			end
		end
	endtask

	assign pending = sphere_q.size();

	always @(posedge clk or negedge arst_n) begin
		sphere_t e;
		if (!arst_n) begin
			cx = 0; cy = 0; cz = 0; crad = 0; cempty = 1;
			errors <= 0;
			sphere_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (sphere_q.size() == 0) begin
					$display("%0t: unexpected beat x=%h y=%h z=%h r=%h e=%b", $time,
						out_x, out_y, out_z, out_radius, is_empty);
					errors <= errors + 1;
				end else begin
					e = sphere_q.pop_front();
					if (e != {out_x, out_y, out_z, out_radius, is_empty}) begin
						$display("%0t: expected x=%h y=%h z=%h r=%h e=%b", $time,
							e.x, e.y, e.z, e.radius, e.empty);
						$display("%0t: actual   x=%h y=%h z=%h r=%h e=%b", $time,
							out_x, out_y, out_z, out_radius, is_empty);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				grow_sphere(req_type, longint'(coord_t'(in_x)), longint'(coord_t'(in_y)),
					longint'(coord_t'(in_z)), longint'(in_radius));
				e.x = rad_t'(cx);
				e.y = rad_t'(cy);
				e.z = rad_t'(cz);
				e.radius = rad_t'(crad);
				e.empty = cempty;
				sphere_q.push_back(e);
			end
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives the bounding sphere accumulator and reports the verdict.
module tb;
	import bsa_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall, req_type;
	logic [COORD_BITS-1:0] in_x, in_y, in_z, in_radius;
	logic out_valid, out_stall;
	logic [COORD_BITS-1:0] out_x, out_y, out_z, out_radius;
	logic is_empty;
	int errors, pending;
	bit calm, hold_long;
	int idle_cycles;

	bounding_sphere_accumulator i_dut (.*);
	bsa_scoreboard i_scoreboard (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	task automatic send_beat(input logic clr, input int x, input int y, input int z,
			input int r);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid = 0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		req_type = clr;
		in_x = x[COORD_BITS-1:0];
		in_y = y[COORD_BITS-1:0];
		in_z = z[COORD_BITS-1:0];
		in_radius = r[COORD_BITS-1:0];
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic int pick_coord();
		if ($urandom_range(0, 3) == 0) return int'($urandom);
		return $signed($urandom_range(0, 8191)) - 4096;
	endfunction

	function automatic int pick_radius();
		case ($urandom_range(0, 3))
			0, 1: return 0;
			2: return $urandom_range(0, 2047);
			default: return int'($urandom);
		endcase
	endfunction

	// stall the result side
	initial begin
		int n;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall = 1;
				repeat (400) @(negedge clk);
				hold_long = 0;
			end
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall = 1;
				n = $urandom_range(1, 15);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall = 0;
			end
		end
	end

	// end the run when no beat is accepted or delivered for too long
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= 20000) begin
				$display("bounding_sphere_accumulator: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		req_type = 0;
		in_x = 0; in_y = 0; in_z = 0; in_radius = 0;
		calm = 0;
		hold_long = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_beat(0, 0, 0, 0, 0);
		send_beat(0, 0, 0, 0, 0);
		send_beat(0, 0, 0, 0, 100);
		send_beat(1, 0, 0, 0, 0);
		send_beat(1, 0, 0, 0, 0);
		send_beat(0, 256, -512, 1024, 0);
		send_beat(0, 300, -500, 1000, 10);
		send_beat(0, 5000, 6000, -7000, 300);
		send_beat(0, 8388607, 8388607, 8388607, 0);
		send_beat(0, -8388608, -8388608, -8388608, 0);
		send_beat(0, 8388607, -8388608, 0, 16777215);
		send_beat(1, -1, -1, -1, -1);
		send_beat(0, -8388608, 8388607, -8388608, 16777215);
		send_beat(0, 8388607, -8388608, 8388607, 16777215);
		send_beat(1, 0, 0, 0, 0);
		send_beat(0, 1, 1, 1, 0);
		send_beat(0, 1, 1, 1, 5);
		send_beat(0, 1, 1, 1, 7);
		send_beat(0, -3, 4, 0, 0);
		send_beat(1, 0, 0, 0, 0);
		send_beat(0, 8388607, 8388607, 8388607, 16777215);
		send_beat(0, 8388607, 8388607, 8388607, 16777215);

		for (int i = 0; i < 1800; i++) begin
			if (i == 400) hold_long = 1;
			if (i == 900) wait (pending == 0);
			if (i == 1600) calm = 1;
			send_beat($urandom_range(0, 15) == 0, pick_coord(), pick_coord(), pick_coord(),
				pick_radius());
		end

		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("bounding_sphere_accumulator: match");
		else $display("bounding_sphere_accumulator: mismatch");
		$finish;
	end

endmodule
